### rtl/core/uigfc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uigfc_pkg
// Types and constants shared by the idle-gap frame collector modules.
// ----------------------------------------------------------------------------
package uigfc_pkg;

   localparam int BUFFER_DEPTH_DEFAULT = 64;

   localparam logic [7:0] IDLE_LIMIT_RESET = 8'd30;
   localparam logic [7:0] IDLE_MAX         = 8'hFF;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register index, taken from the word address bit
   localparam logic REG_IDLE_LIMIT = 1'b0;

   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   typedef struct packed {
      logic       func;
      logic [7:0] rx_byte;
      logic [7:0] tick_ms;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic [6:0] frame_length;
      logic       is_last;
      logic       overflowed;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_SEND
   } state_type;

   typedef struct packed {
      logic take;
      logic rd;
      logic pop;
   } ctrl_cmd_type;

   typedef struct packed {
      logic end_hit;
      logic has_bytes;
      logic last;
   } dp_status_type;

endpackage : uigfc_pkg
`default_nettype wire

### rtl/core/uigfc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uigfc_ctrl
// Controller: takes transactions while idle and walks the buffer at frame end.
// ----------------------------------------------------------------------------
module uigfc_ctrl
   import uigfc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output      logic          req_stall,
   output      logic          rsp_valid,
   input  wire logic          rsp_stall,
   input  wire dp_status_type status,
   output      ctrl_cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.take = 1'b1;
               if (status.end_hit && status.has_bytes) begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            cmd.rd   = 1'b1;
            state_in = S_SEND;
         end
         S_SEND: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               cmd.pop  = 1'b1;
               state_in = status.last ? S_IDLE : S_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_read_then_send: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |=> state_ff == S_SEND)
      else $error("read not followed by send");

   a_next_byte: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEND && !rsp_stall && !status.last) |=> state_ff == S_READ)
      else $error("drain stopped before last byte");

   a_no_take_in_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (req_stall && !cmd.take))
      else $error("input taken while draining");
`endif

endmodule : uigfc_ctrl
`default_nettype wire

### rtl/core/uigfc_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uigfc_dp
// Datapath: frame buffer, byte count, idle counter and result register.
// ----------------------------------------------------------------------------
module uigfc_dp
   import uigfc_pkg::*;
#(
   parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEFAULT
)
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire req_payload_type req_data,
   input  wire logic [7:0]      idle_limit,
   input  wire ctrl_cmd_type    cmd,
   output      dp_status_type   status,
   output      rsp_payload_type rsp_data
);

   localparam int CW = $clog2(BUFFER_DEPTH + 1);
   localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);
   localparam logic [CW-1:0] ONE_C   = CW'(1);

   logic [7:0]    frame_store [BUFFER_DEPTH];
   logic [CW-1:0] count_ff;
   logic [7:0]    idle_ff;
   logic          receiving_ff;
   logic          byte_seen_ff;
   logic          ovf_ff;
   logic [CW-1:0] len_ff;
   logic          ovf_out_ff;
   logic [CW-1:0] ptr_ff;
   logic [7:0]    rd_data_ff;

   logic [8:0]    sum;
   logic [7:0]    idle_in;
   logic          has_room;

   always_comb begin
      sum      = {1'b0, idle_ff} + {1'b0, req_data.tick_ms};
      idle_in  = byte_seen_ff ? 8'd0 : (sum[8] ? IDLE_MAX : sum[7:0]);
      has_room = count_ff < DEPTH_C;
      status.end_hit   = (req_data.func == FUNC_TICK) && receiving_ff
                         && (idle_in > idle_limit);
      status.has_bytes = count_ff != '0;
      status.last      = (ptr_ff + ONE_C) == len_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.take && req_data.func == FUNC_BYTE && has_room) begin
         frame_store[count_ff[AW-1:0]] <= req_data.rx_byte;
      end
      if (cmd.rd) begin
         rd_data_ff <= frame_store[ptr_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idle_ff      <= '0;
         receiving_ff <= 1'b0;
         byte_seen_ff <= 1'b0;
         ovf_ff       <= 1'b0;
         ptr_ff       <= '0;
      end else begin
         if (cmd.take) begin
            if (req_data.func == FUNC_BYTE) begin
               if (has_room) begin
                  count_ff <= count_ff + ONE_C;
               end else begin
                  ovf_ff <= 1'b1;
               end
               receiving_ff <= 1'b1;
               byte_seen_ff <= 1'b1;
            end else if (receiving_ff) begin
               if (status.end_hit) begin
                  count_ff     <= '0;
                  idle_ff      <= '0;
                  receiving_ff <= 1'b0;
                  byte_seen_ff <= 1'b0;
                  ovf_ff       <= 1'b0;
                  ptr_ff       <= '0;
               end else begin
                  idle_ff      <= idle_in;
                  byte_seen_ff <= 1'b0;
               end
            end
         end
         if (cmd.pop) begin
            ptr_ff <= ptr_ff + ONE_C;
         end
      end
   end

   // frame summary held while the buffer drains
   always_ff @(posedge clock) begin
      if (cmd.take && status.end_hit) begin
         len_ff     <= count_ff;
         ovf_out_ff <= ovf_ff;
      end
   end

   always_comb begin
      rsp_data.data_byte    = rd_data_ff;
      rsp_data.frame_length = 7'(len_ff);
      rsp_data.is_last      = status.last;
      rsp_data.overflowed   = ovf_out_ff;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("byte count beyond buffer depth");

   a_read_in_frame: assert property (@(posedge clock) disable iff (reset)
      cmd.rd |-> ptr_ff < len_ff)
      else $error("read past frame end");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.take && status.end_hit) |=> (count_ff == '0 && !receiving_ff && !ovf_ff))
      else $error("frame end left state behind");
`endif

endmodule : uigfc_dp
`default_nettype wire

### rtl/core/uart_idle_gap_frame_collector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uart_idle_gap_frame_collector
// Collects received bytes into a frame that closes after a silent gap.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_stall   req_payload_type
//   rsp      out        rsp_valid / rsp_stall   rsp_payload_type
//   csr      in         apb write / read        idle_limit_ms at 0x0
//
// byte and tick transactions are accepted whenever no frame is draining
// a frame end with bytes reads the buffer out one byte at a time, each held until rsp is not stalled
// req_stall stays high for the whole drain
// synchronous reset clears counters and flags; the buffer and the held frame summary are not cleared
// ----------------------------------------------------------------------------
module uart_idle_gap_frame_collector
   import uigfc_pkg::*;
#(
   parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEFAULT
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire req_payload_type       req_data,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      rsp_payload_type       rsp_data,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output      logic [CSR_DATA_W-1:0] csr_prdata,
   output      logic                  csr_pready
);

   logic [7:0]    idle_limit_ff;
   logic          csr_wr;
   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_limit_ff <= IDLE_LIMIT_RESET;
      end else if (csr_wr && csr_paddr[2] == REG_IDLE_LIMIT) begin
         idle_limit_ff <= csr_pwdata[7:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_IDLE_LIMIT) begin
         csr_prdata = CSR_DATA_W'(idle_limit_ff);
      end
   end

   uigfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   uigfc_dp #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .idle_limit (idle_limit_ff),
      .cmd        (cmd),
      .status     (status),
      .rsp_data   (rsp_data)
   );

endmodule : uart_idle_gap_frame_collector
`default_nettype wire
